### design/pcdg_pkg.sv
// ----------------------------------------------------------------------------
// pcdg_pkg
// Shared types, codes and constants of the probabilistic clock divider grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcdg_pkg;

    // default parameter values
    localparam int CELLS_DEF       = 16;
    localparam int MAX_DIVISOR_DEF = 64;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int CHANCE_BITS_DEF = 4;

    // grid geometry
    localparam int GRID        = 16;
    localparam int GRID_SIDE   = 4;
    localparam int LANE_STRIDE = 4;

    // item field widths
    localparam int OP_W     = 3;
    localparam int IDX_W    = 4;
    localparam int DIV_W    = 7;
    localparam int OFF_W    = 8;
    localparam int CHANCE_W = 5;
    localparam int RAND_W   = 64;
    localparam int SIDE_W   = 4;

    localparam logic signed [OFF_W-1:0] OFFSET_MAX = 8'sd64;
    localparam logic signed [OFF_W-1:0] OFFSET_MIN = -8'sd64;

    typedef enum logic [OP_W-1:0] {
        OP_CLOCK       = 3'd0,
        OP_RESET_COUNT = 3'd1,
        OP_WRITE_CELL  = 3'd2,
        OP_TOGGLE_COL  = 3'd3,
        OP_TOGGLE_ROW  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
        logic wr;
    } t_lane_ctl;

    typedef struct packed {
        logic [SIDE_W-1:0] column_fire;
        logic [SIDE_W-1:0] row_fire;
        logic [GRID-1:0]   cells_fired;
        logic [GRID-1:0]   cells_active;
        logic [SIDE_W-1:0] column_enable;
        logic [SIDE_W-1:0] row_enable;
    } t_result;

endpackage

### design/pcdg_in_if.sv
// ----------------------------------------------------------------------------
// pcdg_in_if
// Command channel: valid/ready handshake with one command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcdg_in_if;
    logic                valid;
    logic                ready;
    logic [2:0]          op;
    logic [3:0]          cell_index;
    logic [6:0]          divisor;
    logic signed [7:0]   offset;
    logic [4:0]          chance;
    logic [63:0]         chance_bits;

    modport source (
        output valid, op, cell_index, divisor, offset, chance, chance_bits,
        input  ready
    );
    modport sink (
        input  valid, op, cell_index, divisor, offset, chance, chance_bits,
        output ready
    );
endinterface

### design/pcdg_out_if.sv
// ----------------------------------------------------------------------------
// pcdg_out_if
// Result channel: valid/ready handshake with one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcdg_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  column_fire;
    logic [3:0]  row_fire;
    logic [15:0] cells_fired;
    logic [15:0] cells_active;
    logic [3:0]  column_enable;
    logic [3:0]  row_enable;

    modport source (
        output valid, column_fire, row_fire, cells_fired, cells_active,
               column_enable, row_enable,
        input  ready
    );
    modport sink (
        input  valid, column_fire, row_fire, cells_fired, cells_active,
               column_enable, row_enable,
        output ready
    );
endinterface

### design/pcdg_lane.sv
// ----------------------------------------------------------------------------
// pcdg_lane
// One grid cell: holds divisor, offset and chance, and tests a beat for
// divisibility with a bit-serial remainder, one target bit per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcdg_lane #(
    parameter int MAX_DIVISOR = pcdg_pkg::MAX_DIVISOR_DEF,
    parameter int COUNT_BITS  = pcdg_pkg::COUNT_BITS_DEF,
    parameter int CHANCE_BITS = pcdg_pkg::CHANCE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pcdg_pkg::t_lane_ctl           i_ctl,
    input  logic [COUNT_BITS-1:0]         i_count,
    input  logic [CHANCE_BITS-1:0]        i_lane_bits,
    input  logic [pcdg_pkg::DIV_W-1:0]    i_divisor,
    input  logic signed [pcdg_pkg::OFF_W-1:0] i_offset,
    input  logic [pcdg_pkg::CHANCE_W-1:0] i_chance,
    output logic                          o_fire,
    output logic                          o_active
);
    import pcdg_pkg::*;

    localparam int DB    = $clog2(MAX_DIVISOR + 1);
    localparam int CHB   = CHANCE_BITS + 1;
    localparam int TBITS = COUNT_BITS + 1;
    localparam int TW    = COUNT_BITS + 2;
    localparam logic [CHB-1:0] CHANCE_FULL = CHB'(1) << CHANCE_BITS;

    logic [DB-1:0]           r_div;
    logic signed [OFF_W-1:0] r_off;
    logic [CHB-1:0]          r_chance;
    logic [TBITS-1:0]        r_tgt;
    logic [DB-1:0]           r_rem;
    logic                    r_neg;
    logic                    r_chance_ok;

    logic [DB-1:0]           n_div;
    logic signed [OFF_W-1:0] n_off;
    logic [CHB-1:0]          n_chance;
    logic signed [TW-1:0]    w_tgt;
    logic [DB:0]             w_shift;
    logic [DB-1:0]           n_rem;

    // saturate written values
    always_comb begin
        if ({1'b0, i_divisor} > 8'(MAX_DIVISOR)) begin
            n_div = DB'(MAX_DIVISOR);
        end else begin
            n_div = DB'(i_divisor);
        end
        if (i_offset > OFFSET_MAX) begin
            n_off = OFFSET_MAX;
        end else if (i_offset < OFFSET_MIN) begin
            n_off = OFFSET_MIN;
        end else begin
            n_off = i_offset;
        end
        if (i_chance > CHANCE_W'(CHANCE_FULL)) begin
            n_chance = CHANCE_FULL;
        end else begin
            n_chance = CHB'(i_chance);
        end
    end

    assign w_tgt   = $signed({2'b00, i_count}) + TW'(r_off);
    assign w_shift = {r_rem, r_tgt[TBITS-1]};

    always_comb begin
        if (w_shift >= {1'b0, r_div}) begin
            n_rem = DB'(w_shift - {1'b0, r_div});
        end else begin
            n_rem = DB'(w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div       <= '0;
            r_off       <= '0;
            r_chance    <= CHANCE_FULL;
            r_rem       <= '0;
            r_neg       <= 1'b0;
            r_chance_ok <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_div    <= n_div;
                r_off    <= n_off;
                r_chance <= n_chance;
            end
            if (i_ctl.start) begin
                r_rem       <= '0;
                r_neg       <= w_tgt[TW-1];
                r_chance_ok <= ({1'b0, i_lane_bits} < r_chance);
            end else if (i_ctl.step) begin
                r_rem <= n_rem;
            end
        end
    end

    // target bits, most significant first
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_tgt <= w_tgt[TBITS-1:0];
        end else if (i_ctl.step) begin
            r_tgt <= {r_tgt[TBITS-2:0], 1'b0};
        end
    end

    assign o_active = (r_div != '0);
    assign o_fire   = o_active && !r_neg && (r_rem == '0) && r_chance_ok;

endmodule

### design/pcdg_merge.sv
// ----------------------------------------------------------------------------
// pcdg_merge
// Fold per-cell fire bits, zeroed for non-clock commands, into column and
// row pulses and gate them with the enables; assemble the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcdg_merge (
    input  logic                          i_is_clock,
    input  logic [pcdg_pkg::GRID-1:0]     i_fired,
    input  logic [pcdg_pkg::GRID-1:0]     i_active,
    input  logic [pcdg_pkg::SIDE_W-1:0]   i_col_en,
    input  logic [pcdg_pkg::SIDE_W-1:0]   i_row_en,
    output pcdg_pkg::t_result             o_result
);
    import pcdg_pkg::*;

    logic [GRID-1:0]   w_fired;
    logic [SIDE_W-1:0] w_cols;
    logic [SIDE_W-1:0] w_rows;

    assign w_fired = i_is_clock ? i_fired : '0;

    always_comb begin
        w_cols = '0;
        w_rows = '0;
        for (int i = 0; i < GRID; i++) begin
            w_cols[i % GRID_SIDE] = w_cols[i % GRID_SIDE] | w_fired[i];
            w_rows[i / GRID_SIDE] = w_rows[i / GRID_SIDE] | w_fired[i];
        end
    end

    assign o_result.column_fire   = w_cols & i_col_en;
    assign o_result.row_fire      = w_rows & i_row_en;
    assign o_result.cells_fired   = w_fired;
    assign o_result.cells_active  = i_active;
    assign o_result.column_enable = i_col_en;
    assign o_result.row_enable    = i_row_en;

endmodule

### design/probabilistic_clock_divider_grid.sv
// ----------------------------------------------------------------------------
// probabilistic_clock_divider_grid
// Clock beat: idle to run, where each cell lane steps its bit-serial
//   remainder over the COUNT_BITS+1 target bits, one bit per step,
//   then to done, which waits for a free result slot.
// Other commands: idle straight to done.
// One command in flight; a new command is taken while a result waits.
// Synchronous active-low reset: count zero, cells inactive, enables all ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module probabilistic_clock_divider_grid #(
    parameter int CELLS       = pcdg_pkg::CELLS_DEF,
    parameter int MAX_DIVISOR = pcdg_pkg::MAX_DIVISOR_DEF,
    parameter int COUNT_BITS  = pcdg_pkg::COUNT_BITS_DEF,
    parameter int CHANCE_BITS = pcdg_pkg::CHANCE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcdg_in_if.sink    i_cmd,
    pcdg_out_if.source o_res
);
    import pcdg_pkg::*;

    localparam int TBITS     = COUNT_BITS + 1;
    localparam int STEP_BITS = $clog2(TBITS);

    t_state                r_state, n_state;
    logic [STEP_BITS-1:0]  r_step, n_step;
    logic [COUNT_BITS-1:0] r_count;
    logic [SIDE_W-1:0]     r_col_en;
    logic [SIDE_W-1:0]     r_row_en;
    logic                  r_is_clock;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out;

    logic                  w_acc;
    logic                  w_load;
    logic [COUNT_BITS-1:0] w_count_inc;
    logic [GRID-1:0]       w_fire;
    logic [GRID-1:0]       w_active;
    t_result               w_result;

    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign w_count_inc = r_count + COUNT_BITS'(1);

    // ---------------- lanes ----------------
    for (genvar g = 0; g < GRID; g++) begin : g_lane
        if (g < CELLS) begin : g_cell
            t_lane_ctl w_ctl;
            assign w_ctl.start = w_acc && (i_cmd.op == OP_CLOCK);
            assign w_ctl.step  = (r_state == S_RUN);
            assign w_ctl.wr    = w_acc && (i_cmd.op == OP_WRITE_CELL)
                                 && (i_cmd.cell_index == IDX_W'(g));

            pcdg_lane #(
                .MAX_DIVISOR (MAX_DIVISOR),
                .COUNT_BITS  (COUNT_BITS),
                .CHANCE_BITS (CHANCE_BITS)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_count     (w_count_inc),
                .i_lane_bits (i_cmd.chance_bits[g*LANE_STRIDE +: CHANCE_BITS]),
                .i_divisor   (i_cmd.divisor),
                .i_offset    (i_cmd.offset),
                .i_chance    (i_cmd.chance),
                .o_fire      (w_fire[g]),
                .o_active    (w_active[g])
            );
        end else begin : g_none
            assign w_fire[g]   = 1'b0;
            assign w_active[g] = 1'b0;
        end
    end

    pcdg_merge u_merge (
        .i_is_clock (r_is_clock),
        .i_fired    (w_fire),
        .i_active   (w_active),
        .i_col_en   (r_col_en),
        .i_row_en   (r_row_en),
        .o_result   (w_result)
    );

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        i_cmd.ready = 1'b0;
        w_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (w_acc) begin
                    if (i_cmd.op == OP_CLOCK) begin
                        n_state = S_RUN;
                        n_step  = STEP_BITS'(TBITS - 1);
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RUN: begin
                n_step = r_step - STEP_BITS'(1);
                if (r_step == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result slot frees up
                if (!r_out_valid || o_res.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ---------------- grid state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_col_en   <= '1;
            r_row_en   <= '1;
            r_is_clock <= 1'b0;
        end else if (w_acc) begin
            r_is_clock <= (i_cmd.op == OP_CLOCK);
            case (i_cmd.op)
                OP_CLOCK:       r_count <= w_count_inc;
                OP_RESET_COUNT: r_count <= '0;
                OP_TOGGLE_COL: begin
                    if (i_cmd.cell_index[3:2] == 2'b00) begin
                        r_col_en <= r_col_en ^ (SIDE_W'(1) << i_cmd.cell_index[1:0]);
                    end
                end
                OP_TOGGLE_ROW: begin
                    if (i_cmd.cell_index[3:2] == 2'b00) begin
                        r_row_en <= r_row_en ^ (SIDE_W'(1) << i_cmd.cell_index[1:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.column_fire   = r_out.column_fire;
    assign o_res.row_fire      = r_out.row_fire;
    assign o_res.cells_fired   = r_out.cells_fired;
    assign o_res.cells_active  = r_out.cells_active;
    assign o_res.column_enable = r_out.column_enable;
    assign o_res.row_enable    = r_out.row_enable;

    // ---------------- assertions ----------------
    a_fired_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.cells_fired & ~o_res.cells_active) == '0))
        else $error("fired cell is not active");

    a_col_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.column_fire & ~o_res.column_enable) == '0)
                     && ((o_res.row_fire & ~o_res.row_enable) == '0))
        else $error("pulse on a disabled column or row");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.cells_fired == '0)
            |-> (o_res.column_fire == '0 && o_res.row_fire == '0))
        else $error("column or row pulse without a fired cell");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd.op == OP_CLOCK)
            |=> (r_count == COUNT_BITS'($past(r_count) + COUNT_BITS'(1))))
        else $error("beat count did not advance");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step != '0) |=> (r_state == S_RUN))
        else $error("lane iteration cut short");

endmodule

### dv/probabilistic_clock_divider_grid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probabilistic_clock_divider_grid_tb
// Self-checking bench for the clock divider grid. Commands go in over the
// command channel and each accepted beat is run through a local model of the
// grid, giving one expected result beat. Every result is checked field by
// field against the oldest pending prediction. The run covers directed
// corners, then random traffic under several idle and stall mixes, and a
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------

module probabilistic_clock_divider_grid_tb;
    import pcdg_pkg::*;

    localparam int          CHANCE_FULL    = 1 << CHANCE_BITS_DEF;
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  OP_SPARE_MID   = 3'd6;
    localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          SETTLE_CYCLES  = 80;
    localparam int          HOLD_CYCLES    = 400;

    typedef struct {
        logic [OP_W-1:0]            op;
        logic [IDX_W-1:0]           idx;
        logic [DIV_W-1:0]           divisor;
        logic signed [OFF_W-1:0]    offset;
        logic [CHANCE_W-1:0]        chance;
        logic [RAND_W-1:0]          chance_bits;
    } t_grid_cmd;

    logic i_clk;
    logic i_rst_n;

    pcdg_in_if  cmd_if ();
    pcdg_out_if res_if ();

    probabilistic_clock_divider_grid i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // grid model state
    logic [COUNT_BITS_DEF-1:0]  beat_cnt;
    logic [DIV_W-1:0]           cell_div [GRID];
    logic signed [OFF_W-1:0]    cell_off [GRID];
    logic [CHANCE_W-1:0]        cell_chc [GRID];
    logic [SIDE_W-1:0]          col_en;
    logic [SIDE_W-1:0]          row_en;

    t_result pending_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_len   = 0;
    int fail_cnt       = 0;
    int cmds_sent      = 0;
    int results_seen   = 0;
    int firings_seen   = 0;
    int cycles         = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_grid_model();
        beat_cnt = '0;
        for (int i = 0; i < GRID; i++) begin
            cell_div[i] = '0;
            cell_off[i] = '0;
            cell_chc[i] = CHANCE_W'(CHANCE_FULL);
        end
        col_en = '1;
        row_en = '1;
    endfunction

    // Apply one command to the model and return the result beat it yields.
    function automatic t_result next_grid_result(input t_grid_cmd c);
        t_result r;
        longint  tgt;
        logic [3:0] lane;
        r = '0;
        case (c.op)
            OP_CLOCK: begin
                beat_cnt = beat_cnt + 1'b1;
                for (int i = 0; i < CELLS_DEF; i++) begin
                    if (cell_div[i] != '0) begin
                        tgt = longint'(beat_cnt) + longint'(cell_off[i]);
                        lane = c.chance_bits[LANE_STRIDE*i +: 4];
                        if (tgt >= 0 && (tgt % longint'(cell_div[i])) == 0
                                && lane < cell_chc[i]) begin
                            r.cells_fired[i]              = 1'b1;
                            r.column_fire[i % GRID_SIDE]  = 1'b1;
                            r.row_fire[i / GRID_SIDE]     = 1'b1;
                        end
                    end
                end
            end
            OP_RESET_COUNT: beat_cnt = '0;
            OP_WRITE_CELL: begin
                if (c.idx < CELLS_DEF) begin
                    cell_div[c.idx] = (c.divisor > MAX_DIVISOR_DEF)
                                      ? DIV_W'(MAX_DIVISOR_DEF) : c.divisor;
                    if (c.offset > OFFSET_MAX)
                        cell_off[c.idx] = OFFSET_MAX;
                    else if (c.offset < OFFSET_MIN)
                        cell_off[c.idx] = OFFSET_MIN;
                    else
                        cell_off[c.idx] = c.offset;
                    cell_chc[c.idx] = (c.chance > CHANCE_FULL)
                                      ? CHANCE_W'(CHANCE_FULL) : c.chance;
                end
            end
            OP_TOGGLE_COL: if (c.idx < GRID_SIDE) col_en[c.idx[1:0]] = ~col_en[c.idx[1:0]];
            OP_TOGGLE_ROW: if (c.idx < GRID_SIDE) row_en[c.idx[1:0]] = ~row_en[c.idx[1:0]];
            default: ;
        endcase
        r.column_fire &= col_en;
        r.row_fire    &= row_en;
        for (int i = 0; i < CELLS_DEF; i++)
            r.cells_active[i] = (cell_div[i] != '0);
        r.column_enable = col_en;
        r.row_enable    = row_en;
        return r;
    endfunction

    function automatic t_grid_cmd mk_cmd(input logic [OP_W-1:0] op, input int idx,
                                         input int div, input int off, input int chc,
                                         input logic [RAND_W-1:0] bits);
        t_grid_cmd c;
        c.op          = op;
        c.idx         = IDX_W'(idx);
        c.divisor     = DIV_W'(div);
        c.offset      = OFF_W'(off);
        c.chance      = CHANCE_W'(chc);
        c.chance_bits = bits;
        return c;
    endfunction

    // Mostly clocks over cells with small divisors, with writes, toggles
    // and count resets mixed in, plus a little noise.
    function automatic t_grid_cmd rand_grid_cmd();
        t_grid_cmd c;
        int pick;
        int roll;
        pick = $urandom_range(99);
        roll = $urandom_range(99);
        c.idx         = IDX_W'($urandom_range(15));
        c.divisor     = DIV_W'($urandom);
        c.offset      = OFF_W'($urandom);
        c.chance      = CHANCE_W'($urandom);
        c.chance_bits = {$urandom, $urandom};
        if (pick < 60) begin
            c.op = OP_CLOCK;
        end else if (pick < 78) begin
            c.op = OP_WRITE_CELL;
            if (roll < 70)
                c.divisor = DIV_W'($urandom_range(6, 1));
            else if (roll < 80)
                c.divisor = '0;
            if ($urandom_range(99) < 70)
                c.offset = OFF_W'(int'($urandom_range(16)) - 8);
            roll = $urandom_range(99);
            if (roll < 50)
                c.chance = CHANCE_W'(CHANCE_FULL);
            else if (roll < 80)
                c.chance = CHANCE_W'($urandom_range(CHANCE_FULL));
        end else if (pick < 83) begin
            c.op = OP_RESET_COUNT;
        end else if (pick < 89) begin
            c.op = OP_TOGGLE_COL;
            if (roll < 80)
                c.idx = IDX_W'($urandom_range(GRID_SIDE - 1));
        end else if (pick < 95) begin
            c.op = OP_TOGGLE_ROW;
            if (roll < 80)
                c.idx = IDX_W'($urandom_range(GRID_SIDE - 1));
        end else begin
            c.op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        end
        return c;
    endfunction

    // Offer one command beat and book its prediction once it is taken.
    // Valid stays high on exit so back-to-back beats are offered without a gap.
    task automatic send_cmd(input t_grid_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.op          <= c.op;
        cmd_if.cell_index  <= c.idx;
        cmd_if.divisor     <= c.divisor;
        cmd_if.offset      <= c.offset;
        cmd_if.chance      <= c.chance;
        cmd_if.chance_bits <= c.chance_bits;
        do @(posedge i_clk); while (cmd_if.ready !== 1'b1);
        pending_results.push_back(next_grid_result(c));
        cmds_sent++;
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_corners();
        logic [RAND_W-1:0] ones;
        logic [RAND_W-1:0] zeros;
        ones  = '1;
        zeros = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // nothing active yet, and spare ops leave everything alone
        send_cmd(mk_cmd(OP_CLOCK, 0, 0, 0, 0, ones));
        send_cmd(mk_cmd(OP_SPARE_FIRST, 0, 1, 0, 16, zeros));
        send_cmd(mk_cmd(OP_SPARE_MID, 15, 127, -128, 31, ones));
        send_cmd(mk_cmd(OP_SPARE_LAST, 7, 64, 64, 0, zeros));
        // writes at and beyond the limits, saturating divisor/offset/chance
        send_cmd(mk_cmd(OP_WRITE_CELL, 0, 1, 0, 16, zeros));
        send_cmd(mk_cmd(OP_WRITE_CELL, 15, 127, 127, 31, ones));
        send_cmd(mk_cmd(OP_WRITE_CELL, 5, 64, -128, 0, zeros));
        send_cmd(mk_cmd(OP_WRITE_CELL, 10, 2, -1, 8, ones));
        send_cmd(mk_cmd(OP_WRITE_CELL, 3, 0, 64, 16, zeros));
        send_cmd(mk_cmd(OP_WRITE_CELL, 6, 3, -64, 15, zeros));
        send_cmd(mk_cmd(OP_CLOCK, 0, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_CLOCK, 0, 0, 0, 0, ones));
        // toggles, including indexes past the grid side
        send_cmd(mk_cmd(OP_TOGGLE_COL, 0, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_TOGGLE_COL, 3, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_TOGGLE_COL, 4, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_TOGGLE_ROW, 1, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_TOGGLE_ROW, 15, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_CLOCK, 0, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_CLOCK, 0, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_RESET_COUNT, 0, 0, 0, 0, ones));
        send_cmd(mk_cmd(OP_CLOCK, 0, 0, 0, 0, zeros));
        send_cmd(mk_cmd(OP_TOGGLE_COL, 0, 0, 0, 0, ones));
        send_cmd(mk_cmd(OP_TOGGLE_ROW, 1, 0, 0, 0, ones));
        send_cmd(mk_cmd(OP_CLOCK, 0, 0, 0, 0, zeros));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++)
            send_cmd(rand_grid_cmd());
        wait_drained();
    endtask

    // Hold the receiver off while the sender keeps pushing, so the block
    // backs up and stalls its command side.
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_len   = HOLD_CYCLES;
        for (int k = 0; k < 24; k++)
            send_cmd(rand_grid_cmd());
        wait_drained();
    endtask

    // receiver ready: random stalls, or a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req_len > 0) begin
                hold_left    = hold_req_len;
                hold_req_len = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            results_seen++;
            firings_seen += $countones(res_if.cells_fired);
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction pending");
                fail_cnt++;
            end else begin
                e = pending_results.pop_front();
                check_field("column_fire", e.column_fire, res_if.column_fire);
                check_field("row_fire", e.row_fire, res_if.row_fire);
                check_field("cells_fired", e.cells_fired, res_if.cells_fired);
                check_field("cells_active", e.cells_active, res_if.cells_active);
                check_field("column_enable", e.column_enable, res_if.column_enable);
                check_field("row_enable", e.row_enable, res_if.row_enable);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("probabilistic_clock_divider_grid: mismatch");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.op          <= OP_CLOCK;
        cmd_if.cell_index  <= '0;
        cmd_if.divisor     <= '0;
        cmd_if.offset      <= '0;
        cmd_if.chance      <= '0;
        cmd_if.chance_bits <= '0;
        reset_grid_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_traffic(440, 0, 0);
        test_random_traffic(440, 83, 0);
        test_random_traffic(440, 0, 83);
        test_result_backpressure();
        test_random_traffic(430, 12, 12);

        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            fail_cnt++;
        end
        $display("covered corners, spare ops, saturating writes and toggles, then random");
        $display("traffic: %0d commands, %0d results, %0d cell firings, %0d cycles",
                 cmds_sent, results_seen, firings_seen, cycles);
        if (fail_cnt == 0)
            $display("probabilistic_clock_divider_grid: match");
        else
            $display("probabilistic_clock_divider_grid: mismatch");
        $finish;
    end

endmodule

### probabilistic_clock_divider_grid.f
design/pcdg_pkg.sv
design/pcdg_in_if.sv
design/pcdg_out_if.sv
design/pcdg_lane.sv
design/pcdg_merge.sv
design/probabilistic_clock_divider_grid.sv
dv/probabilistic_clock_divider_grid_tb.sv
